// ===== src/fsl_pkg.sv =====
// fsl_pkg: shared widths, codes, constants and control/status types of the
// flow sensor linearizer; no dependencies, compiled first
package fsl_pkg;

   // default for the longest averaging or calibration run
   localparam int MAX_SAMPLES_DEF = 255;

   // field widths
   localparam int RAW_W      = 16;
   localparam int CNT_IN_W   = 8;
   localparam int OFS_W      = 21;
   localparam int SV_W       = 22;
   localparam int SPD_W      = 19;
   localparam int VOL_W      = 32;
   localparam int SUM_W      = 32;
   localparam int KIND_W     = 2;
   localparam int REF_W      = 20;
   localparam int SCALE_W    = 20;
   localparam int FS_W       = 16;
   localparam int AREA_W     = 24;
   localparam int RV_W       = 21;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // shared arithmetic units
   localparam int MUL_W     = 24;
   localparam int DIV_NUM_W = 36;
   localparam int DIV_DEN_W = 16;
   localparam int H_W       = 25;

   // request kinds
   localparam logic [KIND_W-1:0] CMD_SINGLE      = 2'd0;
   localparam logic [KIND_W-1:0] CMD_AVERAGE     = 2'd1;
   localparam logic [KIND_W-1:0] CMD_CALIBRATE   = 2'd2;
   localparam logic [KIND_W-1:0] CMD_LOAD_OFFSET = 2'd3;

   // register indexes
   localparam logic [1:0] REG_ADC_REFERENCE  = 2'd0;
   localparam logic [1:0] REG_VOLTAGE_SCALE  = 2'd1;
   localparam logic [1:0] REG_ADC_FULL_SCALE = 2'd2;
   localparam logic [1:0] REG_PIPE_AREA      = 2'd3;

   // register reset values
   localparam logic [REF_W-1:0]   ADC_REF_RST   = 20'd216269;
   localparam logic [SCALE_W-1:0] VSCALE_RST    = 20'd65536;
   localparam logic [FS_W-1:0]    FULL_SCALE_RST = 16'd1023;
   localparam logic [AREA_W-1:0]  PIPE_AREA_RST = 24'd256;

   // voltages in 1/65536 V
   localparam logic [RV_W-1:0] VOLT_MAX   = 21'd1048576;
   localparam logic [RV_W-1:0] ONE_V      = 21'd65536;
   localparam logic [RV_W-1:0] CONNECT_LO = 21'd32768;   // 0.5 V, exclusive
   localparam logic [RV_W-1:0] CONNECT_HI = 21'd340788;  // first code at or above 5.2 V
   localparam logic [RV_W-1:0] CURVE_LO   = 21'd65536;   // 1.00 V
   localparam logic [RV_W-1:0] CURVE_HI   = 21'd327680;  // 5.00 V

   // curve knees, voltage times 100
   localparam logic [H_W-1:0] H_1V00 = 25'd6553600;
   localparam logic [H_W-1:0] H_1V58 = 25'd10354688;
   localparam logic [H_W-1:0] H_2V88 = 25'd18874368;
   localparam logic [H_W-1:0] H_4V11 = 25'd26935296;

   // segment widths, volts times 100
   localparam logic [DIV_DEN_W-1:0] SLOPE_0 = 16'd58;
   localparam logic [DIV_DEN_W-1:0] SLOPE_1 = 16'd130;
   localparam logic [DIV_DEN_W-1:0] SLOPE_2 = 16'd123;
   localparam logic [DIV_DEN_W-1:0] SLOPE_3 = 16'd89;

   // speeds at the knees, 1/65536 m/s
   localparam logic [SPD_W-1:0] SPEED_1   = 19'd65536;
   localparam logic [SPD_W-1:0] SPEED_2   = 19'd131072;
   localparam logic [SPD_W-1:0] SPEED_3   = 19'd196608;
   localparam logic [SPD_W-1:0] SPEED_MAX = 19'd262144;

   // datapath operations, one per controller step
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_CAPTURE = 5'd1;
   localparam logic [OP_W-1:0] OP_MUL_RAW = 5'd2;
   localparam logic [OP_W-1:0] OP_DIVQ_GO = 5'd3;
   localparam logic [OP_W-1:0] OP_MUL_HI  = 5'd4;
   localparam logic [OP_W-1:0] OP_MUL_LO  = 5'd5;
   localparam logic [OP_W-1:0] OP_RV      = 5'd6;
   localparam logic [OP_W-1:0] OP_CORR    = 5'd7;
   localparam logic [OP_W-1:0] OP_MUL_H   = 5'd8;
   localparam logic [OP_W-1:0] OP_DIVS_GO = 5'd9;
   localparam logic [OP_W-1:0] OP_SPD     = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_VOL = 5'd11;
   localparam logic [OP_W-1:0] OP_VOL     = 5'd12;
   localparam logic [OP_W-1:0] OP_ACC     = 5'd13;
   localparam logic [OP_W-1:0] OP_DIVA_GO = 5'd14;
   localparam logic [OP_W-1:0] OP_AVG     = 5'd15;
   localparam logic [OP_W-1:0] OP_EMIT    = 5'd16;

   typedef struct packed {
      logic [REF_W-1:0]   adc_reference;
      logic [SCALE_W-1:0] voltage_scale;
      logic [FS_W-1:0]    adc_full_scale;
      logic [AREA_W-1:0]  pipe_area;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] cmd;
      logic              fs_zero;
      logic              div_done;
      logic              run_end;
      logic              out_free;
   } dp_status_type;

endpackage

// ===== src/fsl_div.sv =====
// fsl_div: unsigned restoring divider, two quotient bits per cycle
// depends on fsl_pkg for default widths
module fsl_div #(
   parameter int NUM_W = fsl_pkg::DIV_NUM_W,
   parameter int DEN_W = fsl_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quotient,
   output logic             done
);
   import fsl_pkg::*;

   localparam int STEPS = NUM_W / 2;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   r1, r2;
   logic             ge1, ge2;
   logic [DEN_W-1:0] rem1, rem2;

   // two dependent subtract steps
   always_comb begin
      r1   = {rem_ff, num_ff[NUM_W-1]};
      ge1  = r1 >= {1'b0, den_ff};
      rem1 = ge1 ? DEN_W'(r1 - {1'b0, den_ff}) : r1[DEN_W-1:0];
      r2   = {rem1, num_ff[NUM_W-2]};
      ge2  = r2 >= {1'b0, den_ff};
      rem2 = ge2 ? DEN_W'(r2 - {1'b0, den_ff}) : r2[DEN_W-1:0];
   end

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = CNT_W'(STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-3:0], ge1, ge2};
         rem_in = rem2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider left busy without done");

endmodule

// ===== src/fsl_datapath.sv =====
// fsl_datapath: item registers, shared multiplier, divider, run state and
// result register; depends on fsl_pkg and fsl_div
module fsl_datapath #(
   parameter int MAX_SAMPLES = fsl_pkg::MAX_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fsl_pkg::cfg_type                  cfg,
   input  fsl_pkg::dp_cmd_type               cmd,
   output fsl_pkg::dp_status_type            status,
   input  logic [fsl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [fsl_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fsl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [fsl_pkg::KIND_W-1:0]        rsp_tuser
);
   import fsl_pkg::*;

   localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES + 1) : 1;
   localparam logic [CNT_IN_W-1:0] MAX_TGT = CNT_IN_W'(MAX_SAMPLES);
   localparam logic signed [22:0] V_POS = 23'sd1048576;
   localparam logic signed [22:0] V_NEG = -23'sd1048576;

   // item
   logic [KIND_W-1:0]       cmd_ff, cmd_in;
   logic [RAW_W-1:0]        raw_ff, raw_in;
   logic [CNT_W-1:0]        target_ff, target_in;
   // kept state
   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic [SUM_W-1:0]        run_sum_ff, run_sum_in;
   logic [CNT_W-1:0]        run_cnt_ff, run_cnt_in;
   logic                    run_end_ff, run_end_in;
   // working values
   logic [2*MUL_W-1:0]      prod_ff, prod_in;
   logic [37:0]             acc_ff, acc_in;
   logic [RV_W-1:0]         rv_ff, rv_in;
   logic signed [SV_W-1:0]  v_ff, v_in;
   logic                    in_range_ff, in_range_in;
   logic [SPD_W-1:0]        spd_base_ff, spd_base_in;
   logic [SPD_W-1:0]        speed_ff, speed_in;
   logic [VOL_W-1:0]        vol_ff, vol_in;
   logic                    con_ff, con_in;
   logic signed [SV_W-1:0]  sv_ff, sv_in;
   // result register
   logic                    out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]       out_kind_ff;
   logic [RSP_DATA_W-1:0]   out_data_ff;

   logic [MUL_W-1:0]        mul_a, mul_b;
   logic                    div_start, div_done;
   logic [DIV_NUM_W-1:0]    div_numer, div_quo;
   logic [DIV_DEN_W-1:0]    div_denom;

   logic [CNT_IN_W-1:0]     tgt8;
   logic [55:0]             rv_full;
   logic signed [22:0]      diff, vclamp;
   logic [H_W-1:0]          h;
   logic [50:0]             p6;
   logic [CNT_W-1:0]        cnt_next;
   logic [SUM_W-1:0]        avg;
   logic [RV_W-1:0]         avg_v;
   logic                    fs_zero, out_free;

   assign fs_zero  = cfg.adc_full_scale == '0;
   assign out_free = !out_valid_ff || rsp_tready;
   assign h        = prod_ff[H_W-1:0];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_RAW: begin
            mul_a = MUL_W'(raw_ff);
            mul_b = MUL_W'(cfg.adc_reference);
         end
         OP_MUL_HI: begin
            mul_a = MUL_W'(div_quo[35:18]);
            mul_b = MUL_W'(cfg.voltage_scale);
         end
         OP_MUL_LO: begin
            mul_a = MUL_W'(div_quo[17:0]);
            mul_b = MUL_W'(cfg.voltage_scale);
         end
         OP_MUL_H: begin
            mul_a = MUL_W'(v_ff[18:0]);
            mul_b = MUL_W'(100);
         end
         OP_MUL_VOL: begin
            mul_a = MUL_W'(speed_ff);
            mul_b = cfg.pipe_area;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      spd_base_in = spd_base_ff;
      case (cmd.op)
         OP_DIVQ_GO: begin
            div_start = 1'b1;
            div_numer = prod_ff[DIV_NUM_W-1:0];
            div_denom = cfg.adc_full_scale;
         end
         OP_DIVS_GO: begin
            // pick the curve segment from voltage times 100
            div_start = 1'b1;
            if (h <= H_1V58) begin
               div_numer   = DIV_NUM_W'(h - H_1V00);
               div_denom   = SLOPE_0;
               spd_base_in = '0;
            end else if (h <= H_2V88) begin
               div_numer   = DIV_NUM_W'(h - H_1V58);
               div_denom   = SLOPE_1;
               spd_base_in = SPEED_1;
            end else if (h <= H_4V11) begin
               div_numer   = DIV_NUM_W'(h - H_2V88);
               div_denom   = SLOPE_2;
               spd_base_in = SPEED_2;
            end else begin
               div_numer   = DIV_NUM_W'(h - H_4V11);
               div_denom   = SLOPE_3;
               spd_base_in = SPEED_3;
            end
         end
         OP_DIVA_GO: begin
            div_start = 1'b1;
            div_numer = DIV_NUM_W'(run_sum_ff);
            div_denom = DIV_DEN_W'(run_cnt_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   fsl_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .quotient (div_quo),
      .done     (div_done)
   );

   // step actions
   always_comb begin
      cmd_in      = cmd_ff;
      raw_in      = raw_ff;
      target_in   = target_ff;
      offset_in   = offset_ff;
      run_sum_in  = run_sum_ff;
      run_cnt_in  = run_cnt_ff;
      run_end_in  = run_end_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      rv_in       = rv_ff;
      v_in        = v_ff;
      in_range_in = in_range_ff;
      speed_in    = speed_ff;
      vol_in      = vol_ff;
      con_in      = con_ff;
      sv_in       = sv_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      tgt8     = req_tdata[23:16];
      rv_full  = {acc_ff, 18'b0} + 56'(prod_ff[37:0]);
      diff     = $signed({2'b00, rv_ff}) - 23'(offset_ff);
      vclamp   = (diff > V_POS) ? V_POS : ((diff < V_NEG) ? V_NEG : diff);
      p6       = ({3'b000, prod_ff} << 2) + ({3'b000, prod_ff} << 1);
      cnt_next = run_cnt_ff + 1'b1;
      avg      = div_quo[SUM_W-1:0];
      avg_v    = (avg > SUM_W'(VOLT_MAX)) ? VOLT_MAX : avg[RV_W-1:0];

      case (cmd.op)
         OP_CAPTURE: begin
            cmd_in   = req_tuser;
            raw_in   = req_tdata[15:0];
            if (tgt8 == '0) begin
               target_in = CNT_W'(1);
            end else if (tgt8 > MAX_TGT) begin
               target_in = CNT_W'(MAX_TGT);
            end else begin
               target_in = CNT_W'(tgt8);
            end
            rv_in    = '0;
            v_in     = '0;
            speed_in = '0;
            vol_in   = '0;
            con_in   = 1'b0;
            sv_in    = '0;
            // calibration starts from a cleared offset
            if (req_tuser == CMD_LOAD_OFFSET) begin
               offset_in = $signed(req_tdata[44:24]);
            end else if (req_tuser == CMD_CALIBRATE) begin
               offset_in = '0;
            end
         end
         OP_MUL_RAW, OP_MUL_HI, OP_MUL_H, OP_MUL_VOL: begin
            prod_in = mul_a * mul_b;
         end
         OP_MUL_LO: begin
            acc_in  = prod_ff[37:0];
            prod_in = mul_a * mul_b;
         end
         OP_RV: begin
            rv_in = (rv_full[55:16] > 40'(VOLT_MAX)) ? VOLT_MAX : rv_full[36:16];
         end
         OP_CORR: begin
            if (fs_zero) begin
               v_in        = '0;
               con_in      = 1'b0;
               in_range_in = 1'b0;
            end else begin
               v_in        = SV_W'(vclamp);
               con_in      = (rv_ff > CONNECT_LO) && (rv_ff < CONNECT_HI);
               in_range_in = (vclamp >= $signed(23'(CURVE_LO)))
                          && (vclamp <= $signed(23'(CURVE_HI)));
            end
            sv_in = fs_zero ? '0 : SV_W'(vclamp);
         end
         OP_SPD: begin
            speed_in = in_range_ff ? SPD_W'(div_quo[SPD_W-1:0] + spd_base_ff) : '0;
         end
         OP_VOL: begin
            // speed and area bound the product well below 32 bits
            vol_in = (p6[50:48] != '0) ? '1 : p6[47:16];
         end
         OP_ACC: begin
            run_sum_in = run_sum_ff
                       + ((cmd_ff == CMD_AVERAGE) ? SUM_W'(speed_ff) : SUM_W'(v_ff));
            run_cnt_in = cnt_next;
            run_end_in = (cnt_next != '0) && (cnt_next >= target_ff);
         end
         OP_AVG: begin
            if (cmd_ff == CMD_AVERAGE) begin
               speed_in = (avg > SUM_W'(SPEED_MAX)) ? SPEED_MAX : avg[SPD_W-1:0];
            end else begin
               sv_in     = $signed(SV_W'(avg_v));
               offset_in = $signed(avg_v - ONE_V);
            end
            run_sum_in = '0;
            run_cnt_in = '0;
            run_end_in = 1'b0;
         end
         OP_EMIT: begin
            out_valid_in = 1'b1;
         end
         default: begin
            run_end_in = run_end_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         run_sum_ff   <= '0;
         run_cnt_ff   <= '0;
         run_end_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         run_sum_ff   <= run_sum_in;
         run_cnt_ff   <= run_cnt_in;
         run_end_ff   <= run_end_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      raw_ff      <= raw_in;
      target_ff   <= target_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rv_ff       <= rv_in;
      v_ff        <= v_in;
      in_range_ff <= in_range_in;
      spd_base_ff <= spd_base_in;
      speed_ff    <= speed_in;
      vol_ff      <= vol_in;
      con_ff      <= con_in;
      sv_ff       <= sv_in;
      if (cmd.op == OP_EMIT) begin
         out_kind_ff <= cmd_ff;
         out_data_ff <= {1'b0, offset_ff, con_ff, vol_ff, speed_ff, sv_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   assign status.cmd      = cmd_ff;
   assign status.fs_zero  = fs_zero;
   assign status.div_done = div_done;
   assign status.run_end  = run_end_ff;
   assign status.out_free = out_free;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> out_free)
      else $error("result loaded over an untaken result");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_cnt_ff <= CNT_W'(MAX_TGT))
      else $error("run counter beyond longest run");

   a_speed_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (speed_ff <= SPEED_MAX))
      else $error("flow speed above curve end");

endmodule

// ===== src/fsl_ctrl.sv =====
// fsl_ctrl: sequencing state machine of the flow sensor linearizer
// depends on fsl_pkg for operation codes and control/status types
module fsl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fsl_pkg::dp_status_type status,
   output fsl_pkg::dp_cmd_type    cmd
);
   import fsl_pkg::*;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE      = 5'd0;
   localparam logic [ST_W-1:0] S_DISPATCH  = 5'd1;
   localparam logic [ST_W-1:0] S_MUL_RAW   = 5'd2;
   localparam logic [ST_W-1:0] S_DIVQ_GO   = 5'd3;
   localparam logic [ST_W-1:0] S_DIVQ_WAIT = 5'd4;
   localparam logic [ST_W-1:0] S_MUL_HI    = 5'd5;
   localparam logic [ST_W-1:0] S_MUL_LO    = 5'd6;
   localparam logic [ST_W-1:0] S_RV        = 5'd7;
   localparam logic [ST_W-1:0] S_CORR      = 5'd8;
   localparam logic [ST_W-1:0] S_MUL_H     = 5'd9;
   localparam logic [ST_W-1:0] S_DIVS_GO   = 5'd10;
   localparam logic [ST_W-1:0] S_DIVS_WAIT = 5'd11;
   localparam logic [ST_W-1:0] S_SPD       = 5'd12;
   localparam logic [ST_W-1:0] S_MUL_VOL   = 5'd13;
   localparam logic [ST_W-1:0] S_VOL       = 5'd14;
   localparam logic [ST_W-1:0] S_ACC       = 5'd15;
   localparam logic [ST_W-1:0] S_RUN_CHK   = 5'd16;
   localparam logic [ST_W-1:0] S_DIVA_GO   = 5'd17;
   localparam logic [ST_W-1:0] S_DIVA_WAIT = 5'd18;
   localparam logic [ST_W-1:0] S_AVG       = 5'd19;
   localparam logic [ST_W-1:0] S_EMIT      = 5'd20;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.cmd == CMD_LOAD_OFFSET) begin
               state_in = S_EMIT;
            end else if (status.fs_zero) begin
               state_in = S_CORR;
            end else begin
               state_in = S_MUL_RAW;
            end
         end
         S_MUL_RAW: begin
            cmd.op   = OP_MUL_RAW;
            state_in = S_DIVQ_GO;
         end
         S_DIVQ_GO: begin
            cmd.op   = OP_DIVQ_GO;
            state_in = S_DIVQ_WAIT;
         end
         S_DIVQ_WAIT: begin
            if (status.div_done) begin
               state_in = S_MUL_HI;
            end
         end
         S_MUL_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = S_RV;
         end
         S_RV: begin
            cmd.op   = OP_RV;
            state_in = S_CORR;
         end
         S_CORR: begin
            cmd.op   = OP_CORR;
            state_in = (status.cmd == CMD_CALIBRATE) ? S_ACC : S_MUL_H;
         end
         S_MUL_H: begin
            cmd.op   = OP_MUL_H;
            state_in = S_DIVS_GO;
         end
         S_DIVS_GO: begin
            cmd.op   = OP_DIVS_GO;
            state_in = S_DIVS_WAIT;
         end
         S_DIVS_WAIT: begin
            if (status.div_done) begin
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            cmd.op   = OP_SPD;
            state_in = (status.cmd == CMD_SINGLE) ? S_MUL_VOL : S_ACC;
         end
         S_MUL_VOL: begin
            cmd.op   = OP_MUL_VOL;
            state_in = S_VOL;
         end
         S_VOL: begin
            cmd.op   = OP_VOL;
            state_in = S_EMIT;
         end
         S_ACC: begin
            cmd.op   = OP_ACC;
            state_in = S_RUN_CHK;
         end
         S_RUN_CHK: begin
            state_in = status.run_end ? S_DIVA_GO : S_IDLE;
         end
         S_DIVA_GO: begin
            cmd.op   = OP_DIVA_GO;
            state_in = S_DIVA_WAIT;
         end
         S_DIVA_WAIT: begin
            if (status.div_done) begin
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            cmd.op   = OP_AVG;
            state_in = (status.cmd == CMD_AVERAGE) ? S_MUL_VOL : S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/flow_sensor_linearizer_unit.sv =====
// flow_sensor_linearizer_unit: top level with register port, controller and
// datapath; depends on fsl_pkg, fsl_ctrl, fsl_datapath (and fsl_div below it)
//
// sequence: load offset goes from dispatch straight to the result; a single
//   measure passes the divider twice from accept to rsp_tvalid; the last
//   sample of a run takes a further pass for the average; samples inside a
//   run give no result
// throughput: one request at a time, next accepted when the sequencer is back
//   in idle, even while a result still waits in the output register
// reset: synchronous, active high; clears offset, run sum and count, state
//   machine and result valid; registers return to their default values
module flow_sensor_linearizer_unit #(
   parameter int MAX_SAMPLES = fsl_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // raw_sample[15:0], sample_count[23:16], offset_value[44:24], zero pad
   input  logic [fsl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd[1:0]
   input  logic [fsl_pkg::KIND_W-1:0]          req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sensor_voltage[21:0], flow_speed[40:22], volumetric_flow[72:41],
   // connected[73], zero_offset_now[94:74], zero pad
   output logic [fsl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // result_kind[1:0]
   output logic [fsl_pkg::KIND_W-1:0]          rsp_tuser,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fsl_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fsl_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fsl_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import fsl_pkg::*;

   // configuration registers
   logic [REF_W-1:0]   adc_ref_ff, adc_ref_in;
   logic [SCALE_W-1:0] vscale_ff, vscale_in;
   logic [FS_W-1:0]    full_scale_ff, full_scale_in;
   logic [AREA_W-1:0]  area_ff, area_in;

   logic               csr_wr;
   logic [1:0]         csr_idx;
   cfg_type            cfg;
   dp_cmd_type         dp_cmd;
   dp_status_type      dp_status;

   // write lands in the access phase; no wait states
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   // word addressed, one register per 4 bytes
   assign csr_idx = paddr[3:2];

   always_comb begin
      adc_ref_in    = adc_ref_ff;
      vscale_in     = vscale_ff;
      full_scale_in = full_scale_ff;
      area_in       = area_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_ADC_REFERENCE:  adc_ref_in    = pwdata[REF_W-1:0];
            REG_VOLTAGE_SCALE:  vscale_in     = pwdata[SCALE_W-1:0];
            REG_ADC_FULL_SCALE: full_scale_in = pwdata[FS_W-1:0];
            REG_PIPE_AREA:      area_in       = pwdata[AREA_W-1:0];
            default:            adc_ref_in    = adc_ref_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_ref_ff    <= ADC_REF_RST;
         vscale_ff     <= VSCALE_RST;
         full_scale_ff <= FULL_SCALE_RST;
         area_ff       <= PIPE_AREA_RST;
      end else begin
         adc_ref_ff    <= adc_ref_in;
         vscale_ff     <= vscale_in;
         full_scale_ff <= full_scale_in;
         area_ff       <= area_in;
      end
   end

   // read back, zero extended
   always_comb begin
      case (csr_idx)
         REG_ADC_REFERENCE:  prdata = CSR_DATA_W'(adc_ref_ff);
         REG_VOLTAGE_SCALE:  prdata = CSR_DATA_W'(vscale_ff);
         REG_ADC_FULL_SCALE: prdata = CSR_DATA_W'(full_scale_ff);
         REG_PIPE_AREA:      prdata = CSR_DATA_W'(area_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.adc_reference  = adc_ref_ff;
   assign cfg.voltage_scale  = vscale_ff;
   assign cfg.adc_full_scale = full_scale_ff;
   assign cfg.pipe_area      = area_ff;

   // sequencer: at most one operation per cycle for the datapath
   fsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // arithmetic, run state, zero offset and result register
   fsl_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
